/* hw/rtl/sfbs_pkg.sv */
// Shared types, codes and character tables of the struct format byte swapper.
package sfbs_pkg;

  // Fixed payload widths.
  localparam int KindW   = 2;
  localparam int CharW   = 8;
  localparam int ByteW   = 8;
  localparam int StatusW = 2;
  localparam int TotalW  = 16;
  localparam int LenW    = 4;
  localparam int MaxField = 8;
  localparam int IdxW    = $clog2(MaxField);

  // Request kinds.
  localparam logic [KindW-1:0] KindFormat  = 2'd0;
  localparam logic [KindW-1:0] KindData    = 2'd1;
  localparam logic [KindW-1:0] KindRestart = 2'd2;

  // Result kinds.
  localparam logic ResultStatus = 1'b0;
  localparam logic ResultData   = 1'b1;

  // Status codes; the first three also serve as the sticky error code.
  localparam logic [StatusW-1:0] StatusOk         = 2'd0;
  localparam logic [StatusW-1:0] StatusUnknown    = 2'd1;
  localparam logic [StatusW-1:0] StatusAlign      = 2'd2;
  localparam logic [StatusW-1:0] StatusUnexpected = 2'd3;

  localparam logic [TotalW-1:0] TotalMax = '1;

  // Format characters.
  localparam logic [CharW-1:0] CharGt    = 8'h3E;  // '>'
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharCr    = 8'h0D;
  localparam logic [CharW-1:0] CharLf    = 8'h0A;
  localparam logic [CharW-1:0] CharTab   = 8'h09;
  localparam logic [CharW-1:0] Char0     = 8'h30;
  localparam logic [CharW-1:0] Char9     = 8'h39;
  localparam logic [CharW-1:0] CharX     = 8'h78;  // 'x'
  localparam logic [CharW-1:0] CharC     = 8'h63;  // 'c'
  localparam logic [CharW-1:0] CharLb    = 8'h62;  // 'b'
  localparam logic [CharW-1:0] CharUb    = 8'h42;  // 'B'
  localparam logic [CharW-1:0] CharQm    = 8'h3F;  // '?'
  localparam logic [CharW-1:0] CharLh    = 8'h68;  // 'h'
  localparam logic [CharW-1:0] CharUh    = 8'h48;  // 'H'
  localparam logic [CharW-1:0] CharLi    = 8'h69;  // 'i'
  localparam logic [CharW-1:0] CharUi    = 8'h49;  // 'I'
  localparam logic [CharW-1:0] CharLl    = 8'h6C;  // 'l'
  localparam logic [CharW-1:0] CharUl    = 8'h4C;  // 'L'
  localparam logic [CharW-1:0] CharLf32  = 8'h66;  // 'f'
  localparam logic [CharW-1:0] CharLq    = 8'h71;  // 'q'
  localparam logic [CharW-1:0] CharUq    = 8'h51;  // 'Q'
  localparam logic [CharW-1:0] CharLd    = 8'h64;  // 'd'

  // One accepted request as held in the input register.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [CharW-1:0] format_char;
    logic [ByteW-1:0] data_byte;
  } item_t;

  // A group of results caused by one request; emitted from last_idx down to 0.
  typedef struct packed {
    logic                           result_kind;
    logic [StatusW-1:0]             status;
    logic [TotalW-1:0]              total;
    logic [MaxField-1:0][ByteW-1:0] bytes;
    logic [IdxW-1:0]                last_idx;
  } batch_t;

  // Byte length of a field character, zero for an unknown one.
  function automatic logic [LenW-1:0] char_len(input logic [CharW-1:0] c);
    logic [LenW-1:0] len;
    case (c) inside
      CharX, CharC, CharLb, CharUb, CharQm:      len = 4'd1;
      CharLh, CharUh:                            len = 4'd2;
      CharLi, CharUi, CharLl, CharUl, CharLf32:  len = 4'd4;
      CharLq, CharUq, CharLd:                    len = 4'd8;
      default:                                   len = 4'd0;
    endcase
    return len;
  endfunction

  // Characters that the format skips.
  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == CharGt) || (c == CharSpace) || (c == CharCr) ||
           (c == CharLf) || (c == CharTab);
  endfunction

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= Char0) && (c <= Char9);
  endfunction

endpackage

/* hw/rtl/sfbs_if.sv */
// Request and result channel interfaces of the struct format byte swapper.
interface sfbs_in_if;
  logic                          valid;
  logic                          ready;
  logic [sfbs_pkg::KindW-1:0]    kind;
  logic [sfbs_pkg::CharW-1:0]    format_char;
  logic [sfbs_pkg::ByteW-1:0]    data_byte;

  modport source (output valid, kind, format_char, data_byte, input ready);
  modport sink   (input valid, kind, format_char, data_byte, output ready);
endinterface

interface sfbs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic [sfbs_pkg::StatusW-1:0]  status;
  logic [sfbs_pkg::TotalW-1:0]   total_bytes;
  logic [sfbs_pkg::ByteW-1:0]    data_out;
  logic                          last;

  modport source (output valid, result_kind, status, total_bytes, data_out, last,
                  input ready);
  modport sink   (input valid, result_kind, status, total_bytes, data_out, last,
                  output ready);
endinterface

/* hw/rtl/sfbs_in_stage.sv */
// Input register of the struct format byte swapper.
module sfbs_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  sfbs_in_if.sink         in_i,
  input  logic            take_i,
  output logic            item_valid_o,
  output sfbs_pkg::item_t item_o
);
  import sfbs_pkg::*;

  logic  valid_q;
  item_t item_q;

  // The register refills in the same cycle that the core takes its request.
  assign in_i.ready   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= '{kind: in_i.kind, format_char: in_i.format_char,
                  data_byte: in_i.data_byte};
    end
  end

endmodule

/* hw/rtl/sfbs_core.sv */
// Format decoder, field state and gather buffer of the struct format byte swapper.
module sfbs_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  sfbs_pkg::item_t  item_i,
  input  logic             out_free_i,
  output logic             take_o,
  output logic             batch_valid_o,
  output sfbs_pkg::batch_t batch_o
);
  import sfbs_pkg::*;

  localparam int DigitW = COUNT_WIDTH + 5;
  localparam int ProdW  = COUNT_WIDTH + LenW;
  localparam int SumW   = ((ProdW > TotalW) ? ProdW : TotalW) + 1;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [COUNT_WIDTH-1:0]          pending_q, pending_d;
  logic [LenW-1:0]                 field_bytes_q, field_bytes_d;
  logic [COUNT_WIDTH-1:0]          fields_left_q, fields_left_d;
  logic [IdxW-1:0]                 gcount_q, gcount_d;
  logic [TotalW-1:0]               total_q, total_d;
  logic [StatusW-1:0]              err_q, err_d;
  logic [MaxField-1:0][ByteW-1:0]  gather_q;
  logic                            gather_we;

  logic [LenW-1:0]                 len;
  logic                            misaligned;
  logic [DigitW-1:0]               digit_val;
  logic [COUNT_WIDTH-1:0]          reps;
  logic [ProdW-1:0]                prod;
  logic [SumW-1:0]                 sum;
  logic                            res_valid;
  batch_t                          batch;

  // Field length, alignment against the running total and repeat arithmetic.
  assign len = char_len(item_i.format_char);
  always_comb begin
    case (len)
      4'd2:    misaligned = total_q[0];
      4'd4:    misaligned = |total_q[1:0];
      4'd8:    misaligned = |total_q[2:0];
      default: misaligned = 1'b0;
    endcase
  end

  assign digit_val = DigitW'(pending_q) * DigitW'(10)
                   + DigitW'(item_i.format_char[3:0]);
  assign reps = (pending_q == '0) ? COUNT_WIDTH'(1) : pending_q;
  assign prod = ProdW'(reps) * ProdW'(len);
  assign sum  = SumW'(total_q) + SumW'(prod);

  // Next state and the results of the request in the input register.
  always_comb begin
    pending_d        = pending_q;
    field_bytes_d    = field_bytes_q;
    fields_left_d    = fields_left_q;
    gcount_d         = gcount_q;
    total_d          = total_q;
    err_d            = err_q;
    gather_we        = 1'b0;
    res_valid        = 1'b0;
    batch.result_kind = ResultStatus;
    batch.status     = err_q;
    batch.total      = total_q;
    batch.bytes      = '0;
    batch.last_idx   = '0;

    case (item_i.kind)
      KindFormat: begin
        res_valid = 1'b1;
        if (err_q == StatusOk && !is_blank(item_i.format_char)) begin
          if (is_digit(item_i.format_char)) begin
            pending_d = (digit_val[DigitW-1:COUNT_WIDTH] != '0) ? CountMax
                                                               : digit_val[COUNT_WIDTH-1:0];
          end else if (len == '0) begin
            err_d = StatusUnknown;
          end else if (misaligned) begin
            err_d = StatusAlign;
          end else begin
            pending_d     = '0;
            field_bytes_d = len;
            fields_left_d = reps;
            gcount_d      = '0;
            total_d       = (sum[SumW-1:TotalW] != '0) ? TotalMax : sum[TotalW-1:0];
          end
        end
        batch.status = err_d;
        batch.total  = total_d;
      end
      KindData: begin
        res_valid         = 1'b1;
        batch.result_kind = ResultData;
        batch.bytes[0]    = item_i.data_byte;
        if (err_q != StatusOk || fields_left_q == '0 || field_bytes_q == '0) begin
          batch.status = StatusUnexpected;
        end else if (field_bytes_q == 4'd1) begin
          fields_left_d = fields_left_q - 1'b1;
          batch.status  = StatusOk;
        end else begin
          gather_we    = 1'b1;
          batch.status = StatusOk;
          if (({1'b0, gcount_q} + 4'd1) < field_bytes_q) begin
            // Field still incomplete: hold the byte and report nothing.
            res_valid = 1'b0;
            gcount_d  = gcount_q + 1'b1;
          end else begin
            // Field complete: hand over gathered bytes, drained in reverse.
            for (int i = 0; i < MaxField; i++) begin
              batch.bytes[i] = (IdxW'(i) == gcount_q) ? item_i.data_byte : gather_q[i];
            end
            batch.last_idx = gcount_q;
            gcount_d       = '0;
            fields_left_d  = fields_left_q - 1'b1;
          end
        end
      end
      KindRestart: begin
        res_valid     = 1'b1;
        pending_d     = '0;
        field_bytes_d = '0;
        fields_left_d = '0;
        gcount_d      = '0;
        total_d       = '0;
        err_d         = StatusOk;
        batch.status  = StatusOk;
        batch.total   = '0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // A request leaves when it has no results or when its results fit in the output register.
  assign take_o        = item_valid_i && (!res_valid || out_free_i);
  assign batch_valid_o = item_valid_i && res_valid;
  assign batch_o       = batch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q     <= '0;
      field_bytes_q <= '0;
      fields_left_q <= '0;
      gcount_q      <= '0;
      total_q       <= '0;
      err_q         <= StatusOk;
    end else if (take_o) begin
      pending_q     <= pending_d;
      field_bytes_q <= field_bytes_d;
      fields_left_q <= fields_left_d;
      gcount_q      <= gcount_d;
      total_q       <= total_d;
      err_q         <= err_d;
    end
  end

  // Gather buffer, written with one byte per data request of a multi-byte field.
  always_ff @(posedge clk_i) begin
    if (take_o && gather_we) begin
      gather_q[gcount_q] <= item_i.data_byte;
    end
  end

endmodule

/* hw/rtl/sfbs_out_stage.sv */
// Result register that drains a group of results one per cycle while the receiver is ready.
module sfbs_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             batch_valid_i,
  input  sfbs_pkg::batch_t batch_i,
  output logic             free_o,
  sfbs_out_if.source       out_o
);
  import sfbs_pkg::*;

  logic            valid_q;
  batch_t          batch_q;
  logic [IdxW-1:0] idx_q;
  logic            at_last;

  assign at_last = (idx_q == '0);
  // Free when empty or when the final result of the group leaves this cycle.
  assign free_o  = !valid_q || (at_last && out_o.ready);

  assign out_o.valid       = valid_q;
  assign out_o.result_kind = batch_q.result_kind;
  assign out_o.status      = batch_q.status;
  assign out_o.total_bytes = batch_q.total;
  assign out_o.data_out    = batch_q.bytes[idx_q];
  assign out_o.last        = at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (free_o) begin
      valid_q <= batch_valid_i;
      idx_q   <= batch_i.last_idx;
    end else if (out_o.ready) begin
      idx_q <= idx_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && batch_valid_i) begin
      batch_q <= batch_i;
    end
  end

endmodule

/* hw/rtl/struct_format_byte_swapper.sv */
// Top level of the struct format byte swapper.
// Takes one request per cycle while the input register can refill: format
// characters, data bytes or a restart. A request passes an input register
// and one step of decode logic and its results land in an output register;
// the first result of a request is presented from the output register once
// that register is free and has taken it. Results leave at one per cycle while the
// receiver is ready; while a completed field drains, the bytes of the next
// field are still accepted and gathered, so a stream of data bytes runs at one
// byte per cycle in and out while the receiver is ready. The repeat counters are
// COUNT_WIDTH bits wide and saturate; the byte total saturates at 65535.
module struct_format_byte_swapper #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfbs_in_if.sink     in_i,
  sfbs_out_if.source  out_o
);
  import sfbs_pkg::*;

  logic   take;
  logic   item_valid;
  item_t  item;
  logic   out_free;
  logic   batch_valid;
  batch_t batch;

  sfbs_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  sfbs_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .out_free_i    (out_free),
    .take_o        (take),
    .batch_valid_o (batch_valid),
    .batch_o       (batch)
  );

  sfbs_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .batch_valid_i (batch_valid),
    .batch_i       (batch),
    .free_o        (out_free),
    .out_o         (out_o)
  );

endmodule

/* bench/tb_struct_format_byte_swapper.sv */
// Testbench of the struct format byte swapper: random requests checked against a predictor.
module tb_struct_format_byte_swapper;
  import sfbs_pkg::*;

  localparam int CountW = 16;
  localparam longint CountMax = (longint'(1) << CountW) - 1;
  localparam longint TotalSat = 65535;
  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam int RandomItems = 120;

  // One result as seen on the output channel.
  typedef struct packed {
    logic               result_kind;
    logic [StatusW-1:0] status;
    logic [TotalW-1:0]  total_bytes;
    logic [ByteW-1:0]   data_out;
    logic               last;
  } swap_result_t;

  // Predicts the results of each accepted request and checks the ones that come out.
  class swap_scoreboard;
    swap_result_t    expected_q[$];
    int unsigned     fail_count;
    logic [CountW-1:0] repeat_acc;
    logic [LenW-1:0]   field_len;
    logic [CountW-1:0] fields_todo;
    logic [ByteW-1:0]  gathered[MaxField];
    logic [LenW-1:0]   gathered_n;
    logic [TotalW-1:0] running_total;
    logic [StatusW-1:0] sticky_err;

    function new();
      fail_count = 0;
      clear();
    endfunction

    function void clear();
      repeat_acc    = '0;
      field_len     = '0;
      fields_todo   = '0;
      gathered_n    = '0;
      running_total = '0;
      sticky_err    = StatusOk;
      foreach (gathered[i]) gathered[i] = '0;
    endfunction

    // Byte length of a field character, zero when the character is not a field.
    function int unsigned field_length(logic [CharW-1:0] c);
      case (c)
        CharX, CharC, CharLb, CharUb, CharQm:     return 1;
        CharLh, CharUh:                           return 2;
        CharLi, CharUi, CharLl, CharUl, CharLf32: return 4;
        CharLq, CharUq, CharLd:                   return 8;
        default:                                  return 0;
      endcase
    endfunction

    function void push(logic rk, logic [StatusW-1:0] st, logic [ByteW-1:0] db, logic lst);
      swap_result_t r;
      r.result_kind = rk;
      r.status      = st;
      r.total_bytes = running_total;
      r.data_out    = db;
      r.last        = lst;
      expected_q.push_back(r);
    endfunction

    // A format character updates the repeat count, the field or the sticky error.
    function void take_char(logic [CharW-1:0] c);
      int unsigned len;
      longint      v;
      longint      reps;
      if (sticky_err != StatusOk) return;
      if (c == CharGt || c == CharSpace || c == CharCr || c == CharLf || c == CharTab) return;
      if (c >= Char0 && c <= Char9) begin
        v = longint'(repeat_acc) * 10 + longint'(int'(c) - int'(Char0));
        if (v > CountMax) v = CountMax;
        repeat_acc = CountW'(v);
        return;
      end
      len = field_length(c);
      if (len == 0) begin
        sticky_err = StatusUnknown;
        return;
      end
      if ((int'(running_total) % len) != 0) begin
        sticky_err = StatusAlign;
        return;
      end
      reps = (repeat_acc == 0) ? 1 : longint'(repeat_acc);
      repeat_acc  = '0;
      field_len   = LenW'(len);
      fields_todo = CountW'(reps);
      gathered_n  = '0;
      v = longint'(running_total) + reps * longint'(len);
      if (v > TotalSat) v = TotalSat;
      running_total = TotalW'(v);
    endfunction

    // A data byte is passed, gathered, or flagged when no field takes it.
    function void take_byte(logic [ByteW-1:0] b);
      int n;
      if (sticky_err != StatusOk || fields_todo == 0 || field_len == 0 ||
          field_len > MaxField) begin
        push(ResultData, StatusUnexpected, b, 1'b1);
        return;
      end
      if (field_len == 1) begin
        fields_todo = fields_todo - 1'b1;
        push(ResultData, StatusOk, b, 1'b1);
        return;
      end
      gathered[gathered_n[IdxW-1:0]] = b;
      gathered_n = gathered_n + 1'b1;
      if (gathered_n < field_len) return;
      n = int'(field_len);
      for (int i = 0; i < n; i++) begin
        push(ResultData, StatusOk, gathered[n - 1 - i], i == n - 1);
      end
      gathered_n  = '0;
      fields_todo = fields_todo - 1'b1;
    endfunction

    function void note_request(logic [KindW-1:0] kind, logic [CharW-1:0] fc,
                               logic [ByteW-1:0] db);
      case (kind)
        KindFormat: begin
          take_char(fc);
          push(ResultStatus, sticky_err, '0, 1'b1);
        end
        KindData: take_byte(db);
        KindRestart: begin
          clear();
          push(ResultStatus, StatusOk, '0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(swap_result_t act);
      swap_result_t exp_r;
      if (expected_q.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing expected: kind=%0d status=%0d total=%0d",
                 $time, act.result_kind, act.status, act.total_bytes);
        $display("%0t:          data=%02h last=%0d", $time, act.data_out, act.last);
        return;
      end
      exp_r = expected_q.pop_front();
      if (exp_r.result_kind != act.result_kind || exp_r.status != act.status ||
          exp_r.total_bytes != act.total_bytes || exp_r.data_out != act.data_out ||
          exp_r.last != act.last) begin
        fail_count++;
        $display("%0t: mismatch expected kind=%0d status=%0d total=%0d data=%02h last=%0d",
                 $time, exp_r.result_kind, exp_r.status, exp_r.total_bytes, exp_r.data_out,
                 exp_r.last);
        $display("%0t:          actual   kind=%0d status=%0d total=%0d data=%02h last=%0d",
                 $time, act.result_kind, act.status, act.total_bytes, act.data_out, act.last);
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   idle_en;
  int unsigned sent_count;

  sfbs_in_if  in_if();
  sfbs_out_if out_if();

  swap_scoreboard sb = new();

  logic [CharW-1:0] field_chars[18] = '{CharX, CharC, CharLb, CharUb, CharQm, CharLh, CharUh,
                                        CharLi, CharUi, CharLl, CharUl, CharLf32, CharLq,
                                        CharUq, CharLd, CharX, CharUb, CharLh};
  logic [CharW-1:0] blank_chars[5] = '{CharGt, CharSpace, CharCr, CharLf, CharTab};

  struct_format_byte_swapper #(
    .COUNT_WIDTH(CountW)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // The receiver stalls at random while idling is enabled.
  always @(posedge clk_i) begin
    out_if.ready <= !idle_en || ($urandom_range(0, 99) >= 9);
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result('{out_if.result_kind, out_if.status, out_if.total_bytes,
                        out_if.data_out, out_if.last});
    end
  end

  // Offers one request, with a random gap first, and notes it once accepted.
  task automatic send_item(logic [KindW-1:0] kind, logic [CharW-1:0] fc, logic [ByteW-1:0] db);
    while (idle_en && $urandom_range(0, 99) < 9) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= kind;
    in_if.format_char <= fc;
    in_if.data_byte   <= db;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_request(kind, fc, db);
    if (kind != KindUnused) sent_count++;
  endtask

  task automatic send_char(logic [CharW-1:0] c);
    send_item(KindFormat, c, ByteW'($urandom_range(0, 255)));
  endtask

  task automatic send_data(logic [ByteW-1:0] b);
    send_item(KindData, CharW'($urandom_range(0, 255)), b);
  endtask

  task automatic send_restart();
    send_item(KindRestart, CharW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)));
  endtask

  // Holds the sender off until every expected result has come out.
  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // One format string with its data, mostly well formed.
  task automatic send_record();
    int unsigned nfields;
    int unsigned idx;
    int unsigned len;
    int unsigned reps;
    int unsigned nbytes;
    int unsigned mode;
    int unsigned pick;
    if (sb.sticky_err != StatusOk || $urandom_range(0, 3) == 0) send_restart();
    nfields = $urandom_range(1, 3);
    for (int f = 0; f < nfields; f++) begin
      if ($urandom_range(0, 4) == 0) send_char(blank_chars[$urandom_range(0, 4)]);
      pick = $urandom_range(0, 9);
      reps = 0;
      if (pick >= 8) reps = $urandom_range(0, 9);
      else if (pick >= 4) reps = $urandom_range(1, 3);
      if (pick >= 4) send_char(Char0 + CharW'(reps));
      // Mostly a field that fits the running total, now and then any field.
      if ($urandom_range(0, 99) < 85) begin
        do begin
          idx = $urandom_range(0, 17);
          len = sb.field_length(field_chars[idx]);
        end while ((int'(sb.running_total) % len) != 0);
      end else begin
        idx = $urandom_range(0, 17);
        len = sb.field_length(field_chars[idx]);
      end
      send_char(field_chars[idx]);
      nbytes = ((reps == 0) ? 1 : reps) * len;
      mode = $urandom_range(0, 99);
      if (mode >= 90) nbytes = nbytes + 1;
      else if (mode >= 80) nbytes = $urandom_range(0, nbytes - 1);
      for (int k = 0; k < nbytes; k++) send_data(ByteW'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned base;
    bit paused;
    int unsigned nnoise;
    rst_ni            = 1'b0;
    idle_en           = 1'b1;
    sent_count        = 0;
    paused            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.kind        = KindFormat;
    in_if.format_char = '0;
    in_if.data_byte   = '0;
    out_if.ready      = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Blanks, a two-byte swap, an unexpected byte and a one-byte field.
    send_restart();
    send_char(CharGt);
    send_char(CharTab);
    send_char(CharLh);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'hA5);
    send_char(CharUb);
    send_data(8'h3C);
    // Misaligned field, then the error stays until a restart.
    send_char(CharLh);
    send_char(CharX);
    send_data(8'h81);
    // A zero repeat count takes the field once.
    send_restart();
    send_char(Char0);
    send_char(CharUq);
    for (int k = 1; k <= 8; k++) send_data(ByteW'(k * 17));
    send_item(KindUnused, 8'hFF, 8'hFF);
    send_char(8'hFF);
    // Repeat count and byte total both saturate.
    send_restart();
    repeat (5) send_char(Char9);
    send_char(CharLd);
    send_char(CharC);
    send_data(8'h7E);
    hold_until_drained();

    // Random part: mostly well-formed records, some noise.
    base = sent_count;
    while (sent_count < base + RandomItems) begin
      idle_en = !(sent_count >= base + 50 && sent_count < base + 100);
      if (!paused && sent_count >= base + 110) begin
        paused = 1'b1;
        hold_until_drained();
      end
      if ($urandom_range(0, 99) < 12) begin
        nnoise = $urandom_range(1, 4);
        for (int k = 0; k < nnoise; k++) begin
          send_item(KindW'($urandom_range(0, 3)), CharW'($urandom_range(0, 255)),
                    ByteW'($urandom_range(0, 255)));
        end
      end else begin
        send_record();
      end
    end
    idle_en = 1'b1;
    in_if.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
